// ===== hw/rtl/ascii_to_unsigned_parser_defines.svh =====
// Assertion macros used by the parser core.
`ifndef ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH
`define ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define A2U_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("a2u assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define A2U_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("a2u assertion failed");

`endif

// ===== hw/rtl/a2u_pkg.sv =====
// Shared types, constants and character helpers of the ASCII-to-unsigned parser.
package a2u_pkg;

   localparam int VALUE_WIDTH  = 64;
   localparam int OFFSET_WIDTH = 16;
   localparam int CH_WIDTH     = 8;
   localparam int BASE_WIDTH   = 6;
   localparam int DIGIT_WIDTH  = 5;

   // Character codes.
   localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_WIDTH-1:0] CH_LOW_A = 8'h61;
   localparam logic [CH_WIDTH-1:0] CH_LOW_F = 8'h66;
   localparam logic [CH_WIDTH-1:0] CH_UP_A  = 8'h41;
   localparam logic [CH_WIDTH-1:0] CH_UP_F  = 8'h46;
   localparam logic [CH_WIDTH-1:0] CH_LOW_X = 8'h78;
   localparam logic [CH_WIDTH-1:0] CH_UP_X  = 8'h58;
   localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CH_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_WIDTH-1:0] CH_LF    = 8'h0a;
   localparam logic [CH_WIDTH-1:0] CH_VT    = 8'h0b;
   localparam logic [CH_WIDTH-1:0] CH_FF    = 8'h0c;
   localparam logic [CH_WIDTH-1:0] CH_CR    = 8'h0d;

   // Base codes; zero selects automatic detection, which picks octal, decimal or hex.
   localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;

   // Digit code for a character that is not a hex digit.
   localparam logic [DIGIT_WIDTH-1:0] NO_DIGIT = 5'd16;

   // Parse phases, one-hot.
   typedef enum logic [4:0] {
      PH_IDLE     = 5'b00001,
      PH_SPACE    = 5'b00010,
      PH_PREFIX   = 5'b00100,
      PH_LEADZERO = 5'b01000,
      PH_DIGITS   = 5'b10000
   } phase_type;

   // One request held in the input register.
   typedef struct packed {
      logic [CH_WIDTH-1:0] ch;
      logic                first;
   } req_item_type;

   // Returns the hex digit value of a character, or NO_DIGIT.
   function automatic logic [DIGIT_WIDTH-1:0] hex_value(input logic [CH_WIDTH-1:0] c);
      logic [CH_WIDTH-1:0] d;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         d = c - CH_LOW_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         d = c - CH_UP_A + 8'd10;
      end else begin
         d = CH_WIDTH'(NO_DIGIT);
      end
      return d[DIGIT_WIDTH-1:0];
   endfunction

   // True for the six whitespace characters.
   function automatic logic is_space(input logic [CH_WIDTH-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
   endfunction

endpackage

// ===== hw/rtl/a2u_in_stage.sv =====
// Input register that holds one request until the parse core takes it.
module a2u_in_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [a2u_pkg::CH_WIDTH-1:0]          req_ch,
   input  logic                                  req_first,
   input  logic                                  advance,
   output logic                                  item_valid,
   output a2u_pkg::req_item_type                 item
);

   logic                  valid_ff;
   logic                  valid_in;
   a2u_pkg::req_item_type item_ff;

   // The register frees up when empty or when the core consumes its request.
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads on every accepted request.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.ch    <= req_ch;
         item_ff.first <= req_first;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/a2u_parse_core.sv =====
// Parse state, single-pass character step and result register.
`include "ascii_to_unsigned_parser_defines.svh"

module a2u_parse_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  a2u_pkg::req_item_type                 item,
   input  logic [a2u_pkg::BASE_WIDTH-1:0]        csr_base,
   output logic                                  advance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [a2u_pkg::VALUE_WIDTH-1:0]       rsp_value,
   output logic [a2u_pkg::OFFSET_WIDTH-1:0]      rsp_end_offset
);

   localparam int PROD_WIDTH = a2u_pkg::VALUE_WIDTH + a2u_pkg::BASE_WIDTH;

   // Parse state.
   a2u_pkg::phase_type                  phase_ff, phase_in, ph_cur;
   logic                                minus_ff, minus_in, minus_cur;
   logic [a2u_pkg::VALUE_WIDTH-1:0]     acc_ff, acc_in, acc_cur;
   logic [a2u_pkg::BASE_WIDTH-1:0]      base_ff, base_in, base_cur;
   logic [a2u_pkg::OFFSET_WIDTH-1:0]    cnt_ff, cnt_in, cnt_cur;

   // Result register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [a2u_pkg::VALUE_WIDTH-1:0]     rsp_value_ff, rsp_value_in;
   logic [a2u_pkg::OFFSET_WIDTH-1:0]    rsp_offset_ff;

   // Step decode.
   logic [a2u_pkg::DIGIT_WIDTH-1:0]     digit;
   logic [a2u_pkg::BASE_WIDTH-1:0]      digit_base;
   logic [PROD_WIDTH-1:0]               prod_wide;
   logic                                take_prefix, take_digit, count_step, emit;
   logic                                idle_step;

   // The core steps whenever a request waits and the result slot can take an answer.
   assign advance = item_valid && (!rsp_valid_ff || rsp_ready);

   // A new string starts from cleared state.
   always_comb begin
      if (item.first) begin
         ph_cur    = a2u_pkg::PH_SPACE;
         minus_cur = 1'b0;
         acc_cur   = '0;
         base_cur  = '0;
         cnt_cur   = '0;
      end else begin
         ph_cur    = phase_ff;
         minus_cur = minus_ff;
         acc_cur   = acc_ff;
         base_cur  = base_ff;
         cnt_cur   = cnt_ff;
      end
   end

   assign digit = a2u_pkg::hex_value(item.ch);

   // One character step: phase transitions, base selection and multiply-add.
   always_comb begin
      phase_in    = ph_cur;
      minus_in    = minus_cur;
      base_in     = base_cur;
      acc_in      = acc_cur;
      digit_base  = base_cur;
      take_prefix = 1'b0;
      take_digit  = 1'b0;
      count_step  = 1'b0;
      emit        = 1'b0;
      prod_wide   = '0;

      unique case (ph_cur)
         a2u_pkg::PH_SPACE: begin
            if (a2u_pkg::is_space(item.ch)) begin
               count_step = 1'b1;
            end else if (item.ch == a2u_pkg::CH_MINUS || item.ch == a2u_pkg::CH_PLUS) begin
               minus_in   = (item.ch == a2u_pkg::CH_MINUS);
               count_step = 1'b1;
               phase_in   = a2u_pkg::PH_PREFIX;
            end else begin
               take_prefix = 1'b1;
            end
         end
         a2u_pkg::PH_PREFIX: begin
            take_prefix = 1'b1;
         end
         a2u_pkg::PH_LEADZERO: begin
            if (item.ch == a2u_pkg::CH_LOW_X || item.ch == a2u_pkg::CH_UP_X) begin
               base_in    = a2u_pkg::BASE_HEX;
               count_step = 1'b1;
               phase_in   = a2u_pkg::PH_DIGITS;
            end else begin
               take_digit = 1'b1;
            end
         end
         a2u_pkg::PH_DIGITS: begin
            take_digit = 1'b1;
         end
         a2u_pkg::PH_IDLE: begin
            phase_in = a2u_pkg::PH_IDLE;
         end
         default: begin
            phase_in = a2u_pkg::PH_IDLE;
         end
      endcase

      // The base register is sampled at the first character after whitespace and sign.
      if (take_prefix) begin
         if (csr_base == a2u_pkg::BASE_AUTO && item.ch == a2u_pkg::CH_ZERO) begin
            base_in    = a2u_pkg::BASE_OCT;
            count_step = 1'b1;
            phase_in   = a2u_pkg::PH_LEADZERO;
         end else begin
            digit_base = (csr_base == a2u_pkg::BASE_AUTO) ? a2u_pkg::BASE_DEC : csr_base;
            base_in    = digit_base;
            take_digit = 1'b1;
         end
      end

      // A digit below the base accumulates; anything else ends the parse.
      if (take_digit) begin
         if (digit == a2u_pkg::NO_DIGIT ||
             {{(a2u_pkg::BASE_WIDTH-a2u_pkg::DIGIT_WIDTH){1'b0}}, digit} >= digit_base) begin
            emit     = 1'b1;
            phase_in = a2u_pkg::PH_IDLE;
         end else begin
            prod_wide  = PROD_WIDTH'(acc_cur) * PROD_WIDTH'(digit_base);
            acc_in     = prod_wide[a2u_pkg::VALUE_WIDTH-1:0] +
                         a2u_pkg::VALUE_WIDTH'(digit);
            count_step = 1'b1;
            phase_in   = a2u_pkg::PH_DIGITS;
         end
      end
   end

   // The offset counter saturates at its all-ones value.
   assign cnt_in = (count_step && (cnt_cur != '1)) ? cnt_cur + 1'b1 : cnt_cur;

   assign rsp_value_in = minus_cur ? (~acc_cur + 1'b1) : acc_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= a2u_pkg::PH_IDLE;
         minus_ff <= 1'b0;
         acc_ff   <= '0;
         base_ff  <= '0;
         cnt_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Result valid is set by a stop character and cleared when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_offset_ff <= cnt_cur;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_end_offset = rsp_offset_ff;

   // An idle character without a restart.
   assign idle_step = advance && !item.first && phase_ff == a2u_pkg::PH_IDLE;

   // A stop character always returns the parser to idle.
   `A2U_ASSERT_NEXT(a_stop_goes_idle, clock, reset, advance && emit, phase_ff == a2u_pkg::PH_IDLE)
   // Idle characters without a restart leave the parser idle and give no result.
   `A2U_ASSERT_NEXT(a_idle_holds, clock, reset, idle_step, phase_ff == a2u_pkg::PH_IDLE && !rsp_valid_ff)
   // Within one string the consumed count never goes down.
   `A2U_ASSERT_NEXT(a_count_monotonic, clock, reset, advance && !item.first, cnt_ff >= $past(cnt_ff))
   // Once digits are being taken a nonzero base is in force.
   `A2U_ASSERT_SAME(a_digits_have_base, clock, reset, phase_ff == a2u_pkg::PH_DIGITS, base_ff != '0)

endmodule

// ===== hw/rtl/ascii_to_unsigned_parser.sv =====
// Top level of the streaming ASCII-to-unsigned integer parser.
//
//   Channel   Direction  Handshake                  Payload
//   req       in         req_valid / req_ready      req_ch, req_first
//   rsp       out        rsp_valid / rsp_ready      rsp_value, rsp_end_offset
//   csr       in         csr_write_enable           csr_write_data (number base)
//
// One character request is taken per cycle while no result waits on rsp_ready.
// A request accepted into the input register is parsed from there once the result
// slot is free; each step holds the 64 by 6 multiply-add of the accumulator.
// Reset clears the parse state, the base register and both valid flags.
// While a result waits on rsp_ready the core holds every character, so the input
// register fills and req_ready drops until the result is taken.
module ascii_to_unsigned_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [a2u_pkg::CH_WIDTH-1:0]          req_ch,
   input  logic                                  req_first,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [a2u_pkg::VALUE_WIDTH-1:0]       rsp_value,
   output logic [a2u_pkg::OFFSET_WIDTH-1:0]      rsp_end_offset,
   input  logic                                  csr_write_enable,
   input  logic [a2u_pkg::BASE_WIDTH-1:0]        csr_write_data
);

   logic [a2u_pkg::BASE_WIDTH-1:0] base_ff;
   logic                           item_valid;
   logic                           advance;
   a2u_pkg::req_item_type          item;

   // Number base register; zero selects automatic detection.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= a2u_pkg::BASE_AUTO;
      end else if (csr_write_enable) begin
         base_ff <= csr_write_data;
      end
   end

   a2u_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_ch     (req_ch),
      .req_first  (req_first),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   a2u_parse_core u_parse_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .csr_base       (base_ff),
      .advance        (advance),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_end_offset (rsp_end_offset)
   );

endmodule
